[rtl/bhm_pkg.sv]
`default_nettype none

package bhm_pkg;

  // register field widths
  localparam int LW_W    = 11;
  localparam int FH_W    = 16;
  localparam int PAT_W   = 9;
  localparam int ROW_W   = FH_W + 1;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;
  localparam int REG_IDX_W = 3;

  // register indexes (byte address is 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_PATTERN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ONE_PATTERN  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GRID_KIND    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_FILL    = 3'd5;

  // register reset values
  localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd2;

  // request kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // grid kinds
  localparam logic GRID_SQUARE = 1'b0;
  localparam logic GRID_HEX    = 1'b1;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // 3x3 window, bit index is row*3+col
  localparam int WIN_BITS = 9;
  localparam int HEX_DIRS = 7;
  localparam logic [WIN_BITS-1:0] TOP_ROW   = 9'h007;
  localparam logic [WIN_BITS-1:0] BOT_ROW   = 9'h1C0;
  localparam logic [WIN_BITS-1:0] LEFT_COL  = 9'h049;
  localparam logic [WIN_BITS-1:0] RIGHT_COL = 9'h124;

  // window bit for each direction; hex tables padded past their six neighbors
  localparam logic [3:0] DIR_SQUARE [WIN_BITS] =
    '{4'd4, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3, 4'd0};
  localparam logic [3:0] DIR_HEX_EVEN [WIN_BITS] =
    '{4'd4, 4'd1, 4'd5, 4'd7, 4'd6, 4'd3, 4'd0, 4'd4, 4'd4};
  localparam logic [3:0] DIR_HEX_ODD [WIN_BITS] =
    '{4'd4, 4'd2, 4'd5, 4'd8, 4'd7, 4'd3, 4'd1, 4'd4, 4'd4};

  // pattern and edge settings used by the back end
  typedef struct packed {
    logic [PAT_W-1:0] zero_pat;
    logic [PAT_W-1:0] one_pat;
    logic             grid_kind;
    logic             edge_fill;
  } pat_cfg_t;

  // classification of one queued column step
  typedef struct packed {
    logic pix;       // value written into the middle row
    logic col_zero;  // step at column 0, result belongs to previous row end
    logic have;      // step produces a result
    logic top;       // result row is the first row
    logic bot;       // result row is the last row
    logic left;      // result column is the first column
    logic right;     // result column is the last column
    logic odd;       // result row is odd
    logic last;      // result is the final pixel of the frame
  } item_t;

  // hit-or-miss test of one edge-corrected window
  function automatic logic hm_match(input logic [WIN_BITS-1:0] g,
                                    input logic grid,
                                    input logic odd,
                                    input logic [PAT_W-1:0] zp,
                                    input logic [PAT_W-1:0] op);
    logic       res;
    logic [3:0] idx;
    logic       b;
    res = 1'b1;
    for (int n = 0; n < WIN_BITS; n++) begin
      if (grid == GRID_HEX) begin
        idx = odd ? DIR_HEX_ODD[n] : DIR_HEX_EVEN[n];
      end else begin
        idx = DIR_SQUARE[n];
      end
      b = g[idx];
      if (!(grid == GRID_HEX && n >= HEX_DIRS)) begin
        if (op[n]) begin
          res = res & b;
        end else if (zp[n]) begin
          res = res & ~b;
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/bhm_cfg.sv]
`default_nettype none

module bhm_cfg import bhm_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic      [WW-1:0]     eff_width_o,
  output logic      [FH_W-1:0]   eff_height_o,
  output pat_cfg_t               pat_cfg_o,
  output logic                   restart_o
);

  localparam int CMPW = (WW > LW_W) ? WW : LW_W;
  localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);

  logic [LW_W-1:0]      lw_q, lw_d;
  logic [FH_W-1:0]      fh_q, fh_d;
  pat_cfg_t             pat_q, pat_d;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;
  logic [CMPW-1:0]      lw_ext;

  assign pready = 1'b1;
  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_comb begin
    lw_d  = lw_q;
    fh_d  = fh_q;
    pat_d = pat_q;
    if (wr_en) begin
      unique case (idx)
        REG_LINE_WIDTH:   lw_d = pwdata[LW_W-1:0];
        REG_FRAME_HEIGHT: fh_d = pwdata[FH_W-1:0];
        REG_ZERO_PATTERN: pat_d.zero_pat = pwdata[PAT_W-1:0];
        REG_ONE_PATTERN:  pat_d.one_pat = pwdata[PAT_W-1:0];
        REG_GRID_KIND:    pat_d.grid_kind = pwdata[0];
        REG_EDGE_FILL:    pat_d.edge_fill = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q  <= LINE_WIDTH_RST;
      fh_q  <= FRAME_HEIGHT_RST;
      pat_q <= '0;
    end else begin
      lw_q  <= lw_d;
      fh_q  <= fh_d;
      pat_q <= pat_d;
    end
  end

  // a size change abandons the frame in progress
  assign restart_o = wr_en && (idx == REG_LINE_WIDTH || idx == REG_FRAME_HEIGHT);

  // read back
  always_comb begin
    unique case (idx)
      REG_LINE_WIDTH:   prdata = APB_DW'(lw_q);
      REG_FRAME_HEIGHT: prdata = APB_DW'(fh_q);
      REG_ZERO_PATTERN: prdata = APB_DW'(pat_q.zero_pat);
      REG_ONE_PATTERN:  prdata = APB_DW'(pat_q.one_pat);
      REG_GRID_KIND:    prdata = APB_DW'(pat_q.grid_kind);
      REG_EDGE_FILL:    prdata = APB_DW'(pat_q.edge_fill);
      default:          prdata = '0;
    endcase
  end

  // clamp the size to the supported range
  assign lw_ext = CMPW'(lw_q);
  always_comb begin
    if (lw_q == '0) begin
      eff_width_o = WW'(1);
    end else if (lw_ext > MAXW_C) begin
      eff_width_o = WW'(MAX_WIDTH);
    end else begin
      eff_width_o = WW'(lw_ext);
    end
  end

  assign eff_height_o = (fh_q == '0) ? FH_W'(1) : fh_q;
  assign pat_cfg_o    = pat_q;

endmodule

`default_nettype wire

[rtl/bhm_front.sv]
`default_nettype none

module bhm_front import bhm_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            restart_i,
  input  wire logic [WW-1:0]   eff_width_i,
  input  wire logic [FH_W-1:0] eff_height_i,
  input  wire logic            edge_fill_i,
  input  wire logic            valid_i,
  input  wire logic            req_type_i,
  input  wire logic            src_pixel_i,
  output logic                 ready_o,
  input  wire logic            q_ready_i,
  output logic                 push_o,
  output logic      [AW-1:0]   push_col_o,
  output item_t                push_item_o
);

  logic [AW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             accept, in_frame, drop, col_zero, wrap;
  logic [ROW_W-1:0] h_ext, h_p1;
  logic [WW-1:0]    col_inc;
  item_t            item;

  assign ready_o  = q_ready_i;
  assign accept   = valid_i && q_ready_i;
  assign h_ext    = ROW_W'(eff_height_i);
  assign h_p1     = h_ext + ROW_W'(1);
  assign in_frame = row_q < h_ext;
  // early flush ticks are taken and dropped
  assign drop     = in_frame && (req_type_i == REQ_FLUSH);
  assign push_o   = accept && !drop;
  assign col_zero = (col_q == '0);
  assign col_inc  = WW'(col_q) + WW'(1);
  assign wrap     = col_inc >= eff_width_i;

  // position of the result this step releases
  always_comb begin
    item.pix      = in_frame ? src_pixel_i : edge_fill_i;
    item.col_zero = col_zero;
    if (col_zero) begin
      item.have  = row_q >= ROW_W'(2);
      item.top   = row_q == ROW_W'(2);
      item.bot   = row_q == h_p1;
      item.left  = eff_width_i == WW'(1);
      item.right = 1'b1;
      item.odd   = row_q[0];
    end else begin
      item.have  = row_q != '0;
      item.top   = row_q == ROW_W'(1);
      item.bot   = row_q == h_ext;
      item.left  = col_q == AW'(1);
      item.right = WW'(col_q) == eff_width_i;
      item.odd   = ~row_q[0];
    end
    item.last = col_zero && (row_q == h_p1);
  end

  assign push_item_o = item;
  assign push_col_o  = col_q;

  // raster counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (push_o) begin
      if (item.last) begin
        col_d = '0;
        row_d = '0;
      end else if (wrap) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = AW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

[rtl/bhm_queue.sv]
`default_nettype none

module bhm_queue import bhm_pkg::*; #(
  parameter int DW = 19
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] push_data_i,
  output logic               ready_o,
  output logic               valid_o,
  output logic      [DW-1:0] head_o,
  input  wire logic          pop_i
);

  logic [DW-1:0]   entries_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_AW:0]   count_q;
  logic            do_push, do_pop;

  assign ready_o = count_q != (Q_AW + 1)'(Q_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (Q_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (Q_AW + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bhm_back.sv]
`default_nettype none

module bhm_back import bhm_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          restart_i,
  input  wire pat_cfg_t      pat_cfg_i,
  input  wire logic          q_valid_i,
  input  wire logic [AW-1:0] q_col_i,
  input  wire item_t         q_item_i,
  output logic               pop_o,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output logic               out_pixel_o,
  output logic               frame_last_o,
  output logic               pattern_error_o
);

  // bit 1 upper row, bit 0 middle row
  logic [1:0]          row_mem [MAX_WIDTH];
  logic [1:0]          rd_q;
  logic                fwd_q;
  logic [1:0]          fwd_data_q;
  logic                b_valid_q;
  logic [AW-1:0]       b_col_q;
  item_t               b_item_q;
  logic [WIN_BITS-1:0] win_q;
  logic                out_valid_q, out_pix_q, out_last_q, out_err_q;

  logic                out_free, b_fire;
  logic [1:0]          rd_eff, wr_data;
  logic [WIN_BITS-1:0] win_new, g_raw, edge_mask, g;
  logic                err, pix;

  function automatic logic [WIN_BITS-1:0] shift_col(input logic [WIN_BITS-1:0] w,
                                                    input logic t,
                                                    input logic mi,
                                                    input logic bo);
    return {bo, w[8:7], mi, w[5:4], t, w[2:1]};
  endfunction

  assign out_free = !out_valid_q || m_ready_i;
  assign b_fire   = b_valid_q && out_free;
  assign pop_o    = q_valid_i && (!b_valid_q || b_fire);

  // line stores: previous step to the same column is forwarded
  assign rd_eff  = fwd_q ? fwd_data_q : rd_q;
  assign wr_data = {rd_eff[0], b_item_q.pix};

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      row_mem[b_col_q] <= wr_data;
    end
    if (pop_o) begin
      rd_q <= row_mem[q_col_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      fwd_q      <= b_fire && (b_col_q == q_col_i);
      fwd_data_q <= wr_data;
      b_col_q    <= q_col_i;
      b_item_q   <= q_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (pop_o) begin
      b_valid_q <= 1'b1;
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
    end
  end

  // window and edge correction
  assign win_new = shift_col(win_q, rd_eff[1], rd_eff[0], b_item_q.pix);
  assign g_raw   = b_item_q.col_zero ? shift_col(win_q, 1'b0, 1'b0, 1'b0) : win_new;

  always_comb begin
    edge_mask = '0;
    if (b_item_q.top) edge_mask = edge_mask | TOP_ROW;
    if (b_item_q.bot) edge_mask = edge_mask | BOT_ROW;
    if (b_item_q.left) edge_mask = edge_mask | LEFT_COL;
    if (b_item_q.right) edge_mask = edge_mask | RIGHT_COL;
  end

  assign g   = (g_raw & ~edge_mask) | (pat_cfg_i.edge_fill ? edge_mask : '0);
  assign err = |(pat_cfg_i.zero_pat & pat_cfg_i.one_pat);
  assign pix = err ? 1'b0 : hm_match(g, pat_cfg_i.grid_kind, b_item_q.odd,
                                     pat_cfg_i.zero_pat, pat_cfg_i.one_pat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (restart_i) begin
      win_q <= '0;
    end else if (b_fire) begin
      win_q <= b_item_q.last ? '0 : win_new;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_fire && b_item_q.have) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && b_item_q.have) begin
      out_pix_q  <= pix;
      out_last_q <= b_item_q.last;
      out_err_q  <= err;
    end
  end

  assign m_valid_o       = out_valid_q;
  assign out_pixel_o     = out_pix_q;
  assign frame_last_o    = out_last_q;
  assign pattern_error_o = out_err_q;

  // frame end only at the bottom right corner of a real result
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_item_q.last) |-> (b_item_q.have && b_item_q.bot && b_item_q.right))
    else $error("frame end outside bottom right corner");

  // a fired result reaches the output register
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && b_item_q.have) |=> out_valid_q)
    else $error("result lost on its way out");

  // a column zero step closes the previous row on its right edge
  a_col_zero_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_item_q.col_zero) |-> b_item_q.right)
    else $error("row end result not on right column");

  // the window is clear after the final pixel of a frame
  a_win_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && b_item_q.last) |=> (win_q == '0))
    else $error("window not cleared at frame end");

endmodule

`default_nettype wire

[rtl/binary_hit_or_miss_3x3_unit.sv]
`default_nettype none

// channel   | dir | handshake                | payload
// ----------+-----+--------------------------+---------------------------------------
// s_axis    | in  | s_axis_tvalid/tready     | tdata[0] src_pixel, tuser req_type
// m_axis    | out | m_axis_tvalid/tready     | tdata[0] out_pixel, tlast frame_last,
//           |     |                          | tuser pattern_error
// apb       | in  | psel/penable/pwrite      | 6 registers at byte address 4*index
//
// one item per clock unless stalled; a pixel's result leaves line_width+1 items
// after the pixel and passes the queue, the line store read and the output register
// the line stores are one dual-bit memory read and written once per item
// reset clears counters, window, queue and output valid; line stores are not cleared
// a 4-entry queue parts intake from the window stage, so each side stalls on its own

module binary_hit_or_miss_3x3_unit import bhm_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // stream in
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [0] src_pixel
  input  wire logic              s_axis_tuser,   // [0] req_type
  // stream out
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [7:0]        m_axis_tdata,   // [0] out_pixel
  output logic                   m_axis_tlast,   // frame_last
  output logic                   m_axis_tuser,   // [0] pattern_error
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int QW = AW + $bits(item_t);

  logic [WW-1:0]   eff_width;
  logic [FH_W-1:0] eff_height;
  pat_cfg_t        pat_cfg;
  logic            restart;
  logic            q_ready, push, q_valid, pop;
  logic [AW-1:0]   push_col, q_col;
  item_t           push_item, q_item;
  logic [QW-1:0]   q_head;
  logic            out_pixel;

  bhm_cfg #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .eff_width_o (eff_width),
    .eff_height_o(eff_height),
    .pat_cfg_o   (pat_cfg),
    .restart_o   (restart)
  );

  // intake and classification
  bhm_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .eff_width_i (eff_width),
    .eff_height_i(eff_height),
    .edge_fill_i (pat_cfg.edge_fill),
    .valid_i     (s_axis_tvalid),
    .req_type_i  (s_axis_tuser),
    .src_pixel_i (s_axis_tdata[0]),
    .ready_o     (s_axis_tready),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .push_col_o  (push_col),
    .push_item_o (push_item)
  );

  bhm_queue #(
    .DW(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_col, push_item}),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (pop)
  );

  assign q_col  = q_head[QW-1:$bits(item_t)];
  assign q_item = item_t'(q_head[$bits(item_t)-1:0]);

  // line stores, window and matching
  bhm_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (restart),
    .pat_cfg_i      (pat_cfg),
    .q_valid_i      (q_valid),
    .q_col_i        (q_col),
    .q_item_i       (q_item),
    .pop_o          (pop),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .out_pixel_o    (out_pixel),
    .frame_last_o   (m_axis_tlast),
    .pattern_error_o(m_axis_tuser)
  );

  assign m_axis_tdata = {7'b0, out_pixel};

endmodule

`default_nettype wire

[dv/binary_hit_or_miss_3x3_unit_tb.sv]
`default_nettype none

module binary_hit_or_miss_3x3_unit_tb;
  import bhm_pkg::*;

  localparam int MAX_W = 1024;
  localparam int LIMIT = 16_000_000;

  // writes to these indexes must be ignored
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // window bit per direction, direction 0 in the lowest nibble
  localparam logic [35:0] SQ_DIRS = {4'd0, 4'd3, 4'd6, 4'd7, 4'd8, 4'd5, 4'd2, 4'd1, 4'd4};
  localparam logic [27:0] HEX_EVEN_DIRS = {4'd0, 4'd3, 4'd6, 4'd7, 4'd5, 4'd1, 4'd4};
  localparam logic [27:0] HEX_ODD_DIRS = {4'd1, 4'd3, 4'd7, 4'd8, 4'd5, 4'd2, 4'd4};

  // window bits that fall outside the frame on each border
  localparam logic [8:0] EDGE_TOP = 9'h007;
  localparam logic [8:0] EDGE_BOT = 9'h1C0;
  localparam logic [8:0] EDGE_LEFT = 9'h049;
  localparam logic [8:0] EDGE_RIGHT = 9'h124;

  typedef struct packed {
    logic req;
    logic pix;
  } px_item_t;

  typedef struct packed {
    logic pix;
    logic last;
    logic err;
  } hm_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [0] src_pixel
  logic s_axis_tuser = 1'b0;          // [0] req_type
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [0] out_pixel
  logic m_axis_tlast;                 // frame_last
  logic m_axis_tuser;                 // [0] pattern_error
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  // register shadow
  logic [LW_W-1:0] cur_width;
  logic [FH_W-1:0] cur_height;
  logic [PAT_W-1:0] cur_zpat;
  logic [PAT_W-1:0] cur_opat;
  logic cur_grid;
  logic cur_fill;

  // window state of the predictor
  logic upper_line [MAX_W];
  logic middle_line [MAX_W];
  logic [8:0] win;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned out_pos;

  px_item_t pixel_feed_q[$];
  hm_result_t hit_expect_q[$];

  int unsigned pushed_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned mismatch_cnt = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  logic src_quiet = 1'b0;
  logic snk_quiet = 1'b0;
  int feed_gap = 0;
  int sink_stall = 0;
  int hold_left = 0;

  binary_hit_or_miss_3x3_unit #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk_i = ~clk_i;

  // effective frame size
  function automatic int unsigned line_len();
    if (cur_width == 0) return 1;
    if (cur_width > MAX_W) return MAX_W;
    return 32'(cur_width);
  endfunction

  function automatic int unsigned frame_rows();
    return (cur_height == 0) ? 1 : 32'(cur_height);
  endfunction

  // move the window one column left and load a new right column
  function automatic logic [8:0] slide(input logic [8:0] w, input logic top,
                                       input logic mid, input logic bot);
    return {bot, w[8:7], mid, w[5:4], top, w[2:1]};
  endfunction

  task automatic restart_frame();
    win = '0;
    col_pos = 0;
    row_pos = 0;
    out_pos = 0;
  endtask

  // advance the window by one accepted transaction and queue its result
  task automatic predict_pixel(input logic req, input logic pix);
    int unsigned w, h, total, xi, r, c;
    int n, ndir;
    logic s, up, mid, have, hit, bit_v;
    logic [8:0] g, mask;
    logic [35:0] dirs;
    hm_result_t res;
    w = line_len();
    h = frame_rows();
    total = w * h;
    // flush before the frame is complete does nothing; after it, input is edge fill
    if (row_pos * w + col_pos < total) begin
      if (req == REQ_FLUSH) return;
      s = pix;
    end else begin
      s = cur_fill;
    end
    xi = col_pos;
    up = upper_line[xi];
    mid = middle_line[xi];
    upper_line[xi] = mid;
    middle_line[xi] = s;
    have = 1'b0;
    g = '0;
    r = 0;
    c = 0;
    // column 0 completes the previous row's last pixel
    if (xi == 0) begin
      if (row_pos >= 2) begin
        g = slide(win, 1'b0, 1'b0, 1'b0);
        r = row_pos - 2;
        c = w - 1;
        have = 1'b1;
      end
      win = slide(win, up, mid, s);
    end else begin
      win = slide(win, up, mid, s);
      if (row_pos >= 1) begin
        g = win;
        r = row_pos - 1;
        c = xi - 1;
        have = 1'b1;
      end
    end
    if (xi + 1 >= w) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos = xi + 1;
    end
    if (!have) return;
    // neighbors outside the frame read as edge fill
    mask = '0;
    if (r == 0) mask |= EDGE_TOP;
    if (r + 1 == h) mask |= EDGE_BOT;
    if (c == 0) mask |= EDGE_LEFT;
    if (c + 1 == w) mask |= EDGE_RIGHT;
    g = (g & ~mask) | (cur_fill ? mask : 9'h000);
    // per-direction pattern test
    if (cur_grid == GRID_HEX) begin
      ndir = 7;
      dirs = (r % 2 == 1) ? {8'h00, HEX_ODD_DIRS} : {8'h00, HEX_EVEN_DIRS};
    end else begin
      ndir = 9;
      dirs = SQ_DIRS;
    end
    hit = 1'b1;
    for (n = 0; n < ndir; n++) begin
      bit_v = g[dirs[4*n +: 4]];
      if (cur_opat[n]) hit = hit & bit_v;
      else if (cur_zpat[n]) hit = hit & ~bit_v;
    end
    res.err = |(cur_zpat & cur_opat);
    res.pix = res.err ? 1'b0 : hit;
    res.last = (out_pos + 1 >= total);
    out_pos++;
    if (res.last) restart_frame();
    hit_expect_q.push_back(res);
  endtask

  // register write: setup then access phase
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_LINE_WIDTH: begin
        cur_width = data[LW_W-1:0];
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        cur_height = data[FH_W-1:0];
        restart_frame();
      end
      REG_ZERO_PATTERN: cur_zpat = data[PAT_W-1:0];
      REG_ONE_PATTERN: cur_opat = data[PAT_W-1:0];
      REG_GRID_KIND: cur_grid = data[0];
      REG_EDGE_FILL: cur_fill = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [LW_W-1:0] w, input logic [FH_W-1:0] h,
                           input logic [PAT_W-1:0] zp, input logic [PAT_W-1:0] op,
                           input logic grid, input logic fill);
    apb_write(REG_LINE_WIDTH, APB_DW'(w));
    apb_write(REG_FRAME_HEIGHT, APB_DW'(h));
    apb_write(REG_ZERO_PATTERN, APB_DW'(zp));
    apb_write(REG_ONE_PATTERN, APB_DW'(op));
    apb_write(REG_GRID_KIND, APB_DW'(grid));
    apb_write(REG_EDGE_FILL, APB_DW'(fill));
    @(posedge clk_i);
  endtask

  task automatic feed(input logic req, input logic pix);
    px_item_t it;
    it.req = req;
    it.pix = pix;
    pixel_feed_q.push_back(it);
    pushed_cnt++;
  endtask

  task automatic feed_pixels(input logic [31:0] bits, input int n);
    int k;
    for (k = 0; k < n; k++) feed(REQ_PIXEL, bits[k]);
  endtask

  // raster pixels with occasional stray flushes, then a mixed drain tail
  task automatic queue_frame(input int unsigned npix, input int unsigned ndrain,
                             input int ones, input int noise);
    int unsigned k;
    for (k = 0; k < npix; k++) begin
      if ($urandom_range(0, 99) < noise) feed(REQ_FLUSH, 1'($urandom_range(0, 1)));
      feed(REQ_PIXEL, $urandom_range(0, 99) < ones);
    end
    for (k = 0; k < ndrain; k++) begin
      feed($urandom_range(0, 1) ? REQ_FLUSH : REQ_PIXEL, 1'($urandom_range(0, 1)));
    end
  endtask

  // wait for every transaction and result, then let the pipeline empty
  task automatic settle();
    do @(negedge clk_i); while (taken_cnt != pushed_cnt || hit_expect_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  // input side: accept and predict
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_pixel(s_axis_tuser, s_axis_tdata[0]);
      taken_cnt++;
      in_taken = 1'b1;
    end
  end

  // input driver with random gaps
  always @(negedge clk_i) begin : src_drive
    px_item_t nxt;
    if (rst_ni && (in_taken || !s_axis_tvalid)) begin
      if (in_taken) begin
        in_taken = 1'b0;
        feed_gap = src_quiet ? 0 : $urandom_range(0, 14);
      end
      if (feed_gap > 0) begin
        feed_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_feed_q.size() != 0) begin
        nxt = pixel_feed_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, nxt.pix};
        s_axis_tuser <= nxt.req;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side: compare against the oldest expected result
  always @(posedge clk_i) begin : result_mon
    hm_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_taken = 1'b1;
      result_cnt++;
      if (hit_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("result %0d unexpected: data %h last %b err %b", result_cnt,
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = hit_expect_q.pop_front();
        if (m_axis_tdata !== {7'b0, want.pix} || m_axis_tlast !== want.last ||
            m_axis_tuser !== want.err) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: expected data %h last %b err %b, got data %h last %b err %b",
                     result_cnt, {7'b0, want.pix}, want.last, want.err,
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  // output ready with random stalls and the long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        sink_stall = snk_quiet ? 0 : $urandom_range(0, 14);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #LIMIT;
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus sequence
  initial begin
    int k, nfr, f, ones, phase_no, random_items;
    int unsigned total, npix;
    logic [LW_W-1:0] w;
    logic [FH_W-1:0] h;
    logic [PAT_W-1:0] zp, op;
    logic grid, fill;
    for (k = 0; k < MAX_W; k++) begin
      upper_line[k] = 1'b0;
      middle_line[k] = 1'b0;
    end
    cur_width = LINE_WIDTH_RST;
    cur_height = FRAME_HEIGHT_RST;
    cur_zpat = '0;
    cur_opat = '0;
    cur_grid = GRID_SQUARE;
    cur_fill = 1'b0;
    restart_frame();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // stray flush before the frame, raster pixels, then a pixel acting as flush
    configure(11'd3, 16'd2, 9'h000, 9'h001, GRID_SQUARE, 1'b0);
    feed(REQ_FLUSH, 1'b1);
    feed_pixels(32'b011101, 6);
    feed(REQ_FLUSH, 1'b0);
    feed(REQ_FLUSH, 1'b1);
    feed(REQ_PIXEL, 1'b1);
    settle();

    // zero width and single row, all neighbors from filled edges
    configure(11'd0, 16'd1, 9'h001, 9'h1FE, GRID_SQUARE, 1'b1);
    feed_pixels(32'b0, 1);
    feed(REQ_FLUSH, 1'b1);
    feed(REQ_PIXEL, 1'b0);
    settle();

    // hexagonal grid with odd height and the unused pattern bits set
    configure(11'd2, 16'd3, 9'h180, 9'h003, GRID_HEX, 1'b0);
    feed_pixels(32'b111011, 6);
    repeat (3) feed(REQ_FLUSH, 1'b0);
    settle();

    // writes to indexes past the register file, then overlapping patterns
    apb_write(REG_SPARE_A, $urandom);
    apb_write(REG_SPARE_B, $urandom);
    configure(11'd1, 16'd0, 9'h1FF, 9'h1FF, GRID_SQUARE, 1'b1);
    feed_pixels(32'b1, 1);
    feed(REQ_FLUSH, 1'b0);
    feed(REQ_FLUSH, 1'b1);
    settle();

    // tallest frame, left unfinished and abandoned by the next size write
    configure(11'd1, 16'hFFFF, 9'h000, 9'h000, GRID_SQUARE, 1'b0);
    feed_pixels(32'b1010, 4);
    settle();

    // random phases
    phase_no = 0;
    random_items = 0;
    while (random_items < 700) begin
      case ($urandom_range(0, 19))
        0: w = 11'd0;
        1: w = LW_W'($urandom_range(13, 32));
        default: w = LW_W'($urandom_range(1, 12));
      endcase
      grid = 1'($urandom_range(0, 1));
      fill = 1'($urandom_range(0, 1));
      h = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 7));
      if (grid == GRID_HEX && $urandom_range(0, 3) != 0) h[0] = 1'b0;
      case ($urandom_range(0, 9))
        0: begin zp = 9'h1FF; op = 9'h000; end
        1: begin zp = 9'h000; op = 9'h1FF; end
        2: begin op = PAT_W'($urandom); zp = PAT_W'($urandom) | op; end
        default: begin
          op = PAT_W'($urandom & $urandom);
          zp = PAT_W'($urandom & $urandom) & ~op;
        end
      endcase
      // one backpressure phase and one full-width phase
      if (phase_no == 1) begin w = 11'd8; h = 16'd6; end
      if (phase_no == 3) begin w = 11'd2047; h = 16'd1; end
      configure(w, h, zp, op, grid, fill);
      src_quiet = ($urandom_range(0, 4) == 0) || phase_no == 1;
      snk_quiet = ($urandom_range(0, 4) == 0) && phase_no != 1;
      if (phase_no == 1) hold_left = 300;
      nfr = (w > 32) ? 1 : $urandom_range(1, 3);
      for (f = 0; f < nfr; f++) begin
        total = line_len() * frame_rows();
        ones = $urandom_range(0, 4) * 25;
        if (w > 32) begin
          // full-width row with a few results, dropped by the next size write
          queue_frame(total, 6, ones, 0);
          random_items += total + 6;
        end else if (f == nfr - 1 && $urandom_range(0, 4) == 0) begin
          // broken frame, dropped by the next size write
          npix = $urandom_range(1, total);
          queue_frame(npix, 0, ones, 5);
          random_items += npix;
        end else begin
          queue_frame(total, line_len() + 1, ones, 5);
          random_items += total + line_len() + 1;
        end
      end
      settle();
      phase_no++;
    end

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
